[hw/rtl/cwsf_pkg.sv]
package cwsf_pkg;

    // configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 64;

    localparam logic [CFG_IDX_W-1:0] CFG_LEFT_TAPS   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_RIGHT_TAPS  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_COEFF_WORD0 = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_COEFF_WORD1 = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_COEFF_WORD2 = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_COEFF_WORD3 = 3'd5;

    // window extent registers and derived offsets
    localparam int LR_W = 4;

    // coefficients: four words of four signed lanes
    localparam int COEF_W         = 16;
    localparam int COEF_WORDS     = 4;
    localparam int LANES_PER_WORD = CFG_DATA_W / COEF_W;
    localparam int COEF_LANES     = COEF_WORDS * LANES_PER_WORD;

    localparam logic [CFG_DATA_W-1:0] COEFF_WORD0_RST = 64'd32767;

    // input and result fields
    localparam int SAMPLE_W = 16;
    localparam int OUT_W    = 36;

    // per-frame sample count, saturating
    localparam int CNT_W = 5;
    localparam logic [CNT_W-1:0] CNT_MAX = 5'd31;

    // queue depths (powers of two)
    localparam int JQ_DEPTH  = 4;
    localparam int OQ_DEPTH  = 8;
    localparam int OQ_CNT_W  = $clog2(OQ_DEPTH + 1);

    // control part of one queued job
    typedef struct packed {
        logic             last;
        logic [CNT_W-1:0] k;
        logic [LR_W-1:0]  dstart;
        logic [LR_W-1:0]  lc;
    } t_job_ctl;

    // one result item
    typedef struct packed {
        logic [OUT_W-1:0] smoothed;
        logic             frame_last;
    } t_result;

endpackage

[hw/rtl/cwsf_fifo.sv]
module cwsf_fifo import cwsf_pkg::*; #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_push,
    input  logic [WIDTH-1:0]             i_data,
    output logic                         o_full,
    input  logic                         i_pop,
    output logic                         o_empty,
    output logic [WIDTH-1:0]             o_data,
    output logic [$clog2(DEPTH+1)-1:0]   o_count
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CW    = $clog2(DEPTH + 1);

    logic [DEPTH-1:0][WIDTH-1:0] r_mem;
    logic [PTR_W-1:0]            r_wr_ptr;
    logic [PTR_W-1:0]            r_rd_ptr;
    logic [CW-1:0]               r_count;
    logic                        do_push;
    logic                        do_pop;

    assign o_full  = (r_count == CW'(DEPTH));
    assign o_empty = (r_count == '0);
    assign o_count = r_count;
    assign o_data  = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    // writers must respect full: a dropped item would vanish silently
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_push && o_full))
        else $error("push into full queue");

    a_ptr_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count == '0) |-> (r_rd_ptr == r_wr_ptr))
        else $error("queue pointers disagree with count");

endmodule

[hw/rtl/cwsf_front.sv]
module cwsf_front import cwsf_pkg::*; #(
    parameter int TAPS        = 16,
    parameter int SAMPLE_BITS = 16
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_accept,
    input  logic [SAMPLE_W-1:0]                 i_sample,
    input  logic                                i_frame_end,
    input  logic [LR_W-1:0]                     i_left_taps,
    input  logic [LR_W-1:0]                     i_right_taps,
    output logic                                o_job_push,
    output t_job_ctl                            o_job_ctl,
    output logic [TAPS-1:0][SAMPLE_BITS-1:0]    o_job_win
);

    localparam logic [LR_W:0] TOP_LANE = (LR_W + 1)'(TAPS - 1);

    logic [TAPS-1:0][SAMPLE_BITS-1:0] r_win;
    logic [TAPS-1:0][SAMPLE_BITS-1:0] n_win;
    logic [CNT_W-1:0]                 r_rcv_cnt;
    logic [CNT_W-1:0]                 n_rcv_cnt;
    logic [LR_W:0]                    lc_clamp;
    logic [LR_W:0]                    room;
    logic [LR_W:0]                    rc_clamp;
    logic                             emit;

    // clamp the window so that it fits the tap count
    always_comb begin
        lc_clamp = ({1'b0, i_left_taps} > TOP_LANE) ? TOP_LANE : {1'b0, i_left_taps};
        room     = TOP_LANE - lc_clamp;
        rc_clamp = ({1'b0, i_right_taps} > room) ? room : {1'b0, i_right_taps};
    end

    always_comb begin
        n_win[0] = i_sample[SAMPLE_BITS-1:0];
        for (int a = 1; a < TAPS; a++) begin
            n_win[a] = r_win[a-1];
        end
    end

    always_comb begin
        emit = i_frame_end || (r_rcv_cnt >= CNT_W'(rc_clamp));
        o_job_push       = i_accept && emit;
        o_job_ctl.last   = i_frame_end;
        o_job_ctl.k      = r_rcv_cnt;
        o_job_ctl.lc     = LR_W'(lc_clamp);
        // a flush covers only the indexes that exist
        if (i_frame_end && (r_rcv_cnt < CNT_W'(rc_clamp))) begin
            o_job_ctl.dstart = LR_W'(r_rcv_cnt);
        end else begin
            o_job_ctl.dstart = LR_W'(rc_clamp);
        end
        o_job_win = n_win;
        if (i_frame_end) begin
            n_rcv_cnt = '0;
        end else if (r_rcv_cnt == CNT_MAX) begin
            n_rcv_cnt = r_rcv_cnt;
        end else begin
            n_rcv_cnt = r_rcv_cnt + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rcv_cnt <= '0;
        end else if (i_accept) begin
            r_rcv_cnt <= n_rcv_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            r_win <= n_win;
        end
    end

endmodule

[hw/rtl/cwsf_back.sv]
module cwsf_back import cwsf_pkg::*; #(
    parameter int TAPS        = 16,
    parameter int SAMPLE_BITS = 16
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_job_valid,
    input  t_job_ctl                             i_job_ctl,
    input  logic [TAPS-1:0][SAMPLE_BITS-1:0]     i_job_win,
    output logic                                 o_job_pop,
    input  logic [COEF_LANES-1:0][COEF_W-1:0]    i_coef,
    input  logic [OQ_CNT_W-1:0]                  i_oq_count,
    output logic                                 o_res_push,
    output t_result                              o_res
);

    localparam logic [LR_W-1:0] TOP_LANE = LR_W'(TAPS - 1);
    localparam int BLANES = 2 * TAPS - 1;
    localparam int PW     = SAMPLE_BITS + COEF_W;
    localparam int GROUPS = (TAPS + 3) / 4;
    localparam int UW     = OQ_CNT_W + 1;

    logic                              r_active;
    logic [LR_W-1:0]                   r_d;
    logic [LR_W-1:0]                   cur_d;
    logic [LR_W-1:0]                   center;
    logic [LR_W-1:0]                   sh;
    logic [UW-1:0]                     used;
    logic                              issue;
    logic                              run_done;
    logic [BLANES-1:0][COEF_W-1:0]     b_vec;
    logic [BLANES*COEF_W-1:0]          b_shift;
    logic [TAPS-1:0][COEF_W-1:0]       n_coef;
    logic [TAPS-1:0][SAMPLE_BITS-1:0]  n_samp;

    logic                              r_s0_v;
    logic                              r_s0_last;
    logic [TAPS-1:0][COEF_W-1:0]       r_s0_coef;
    logic [TAPS-1:0][SAMPLE_BITS-1:0]  r_s0_samp;
    logic                              r_s1_v;
    logic                              r_s1_last;
    logic [TAPS-1:0][PW-1:0]           r_s1_prod;
    logic [TAPS-1:0][PW-1:0]           n_prod;
    logic                              r_s2_v;
    logic                              r_s2_last;
    logic [GROUPS-1:0][OUT_W-1:0]      r_s2_part;
    logic [GROUPS-1:0][OUT_W-1:0]      n_part;

    // sequencer: a flush job stays at the queue head until index zero is issued
    always_comb begin
        cur_d    = r_active ? r_d : i_job_ctl.dstart;
        center   = cur_d + i_job_ctl.lc;
        sh       = TOP_LANE - center;
        used     = UW'(i_oq_count) + UW'(r_s0_v) + UW'(r_s1_v) + UW'(r_s2_v);
        issue    = i_job_valid && (used < UW'(OQ_DEPTH));
        run_done = !i_job_ctl.last || (cur_d == '0);
        o_job_pop = issue && run_done;
    end

    // lane a (sample age a) takes coefficient center-a: reversed table, shifted
    always_comb begin
        for (int m = 0; m < BLANES; m++) begin
            if (m < TAPS) begin
                b_vec[m] = i_coef[TAPS-1-m];
            end else begin
                b_vec[m] = '0;
            end
        end
        b_shift = b_vec >> (32'(sh) * COEF_W);
        n_coef  = b_shift[TAPS*COEF_W-1:0];
        for (int a = 0; a < TAPS; a++) begin
            // ages before the start of the frame drop out
            n_samp[a] = (CNT_W'(a) <= i_job_ctl.k) ? i_job_win[a] : '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= 1'b0;
            r_d      <= '0;
            r_s0_v   <= 1'b0;
            r_s1_v   <= 1'b0;
            r_s2_v   <= 1'b0;
        end else begin
            if (issue) begin
                r_active <= !run_done;
                r_d      <= cur_d - 1'b1;
            end
            r_s0_v <= issue;
            r_s1_v <= r_s0_v;
            r_s2_v <= r_s1_v;
        end
    end

    always_comb begin
        for (int a = 0; a < TAPS; a++) begin
            n_prod[a] = $signed(r_s0_samp[a]) * $signed(r_s0_coef[a]);
        end
    end

    always_comb begin
        n_part = '0;
        for (int a = 0; a < TAPS; a++) begin
            n_part[a >> 2] = n_part[a >> 2]
                + {{(OUT_W - PW){r_s1_prod[a][PW-1]}}, r_s1_prod[a]};
        end
    end

    always_ff @(posedge i_clk) begin
        r_s0_coef <= n_coef;
        r_s0_samp <= n_samp;
        r_s0_last <= i_job_ctl.last && (cur_d == '0);
        r_s1_prod <= n_prod;
        r_s1_last <= r_s0_last;
        r_s2_part <= n_part;
        r_s2_last <= r_s1_last;
    end

    always_comb begin
        o_res.smoothed = '0;
        for (int g = 0; g < GROUPS; g++) begin
            o_res.smoothed = o_res.smoothed + r_s2_part[g];
        end
        o_res.frame_last = r_s2_last;
        o_res_push       = r_s2_v;
    end

    // a flush run only continues on the job that started it
    a_run_has_job: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_active |-> i_job_valid)
        else $error("flush run without a job at the queue head");

    // results in flight never exceed the room left in the output queue
    a_credit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        used <= UW'(OQ_DEPTH))
        else $error("result credit overrun");

    a_run_pop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (issue && i_job_ctl.last && (cur_d == '0)) |=> !r_active)
        else $error("flush run did not end at index zero");

endmodule

[hw/rtl/centered_window_smoothing_fir.sv]
// centered-window smoothing fir
//
// input side looks like a queue: drive i_sample/i_frame_end with push, an item
// is taken at a clock edge with push high and full low. i_frame_end marks the
// last sample of a frame and flushes every pending result of that frame.
// result side looks like a queue too: while empty is low the oldest result is
// on o_smoothed/o_frame_last, and it is taken at an edge with pop high.
// o_frame_last is high on the final result of each frame.
// throughput: one item per clock while full is low; a result leaves for every
// sample once R samples beyond its center have arrived. a frame-end item issues
// each index from min(k,R) down to zero into the multiply-add datapath (k = its
// index in the frame), while the front keeps taking items into a four-deep job queue.
// a result passes the job queue, the align, multiply and partial-sum registers
// and the result queue before it is visible.
// when pop stalls, the eight-deep result queue fills, the datapath holds back
// on a credit count, then the job queue fills and full rises.
// the user must write configuration (i_cfg_we/i_cfg_idx/i_cfg_data) only while
// idle; the block does not enforce it. reset: synchronous, active low; queues
// empty, frame count zero, L=R=0, coefficient 0 = 32767 and the others zero.
module centered_window_smoothing_fir import cwsf_pkg::*; #(
    parameter int TAPS        = 16,
    parameter int SAMPLE_BITS = 16
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    // sample channel
    input  logic                   push,
    output logic                   full,
    input  logic [SAMPLE_W-1:0]    i_sample,
    input  logic                   i_frame_end,
    // result channel
    output logic                   empty,
    input  logic                   pop,
    output logic [OUT_W-1:0]       o_smoothed,
    output logic                   o_frame_last,
    // configuration write port
    input  logic                   i_cfg_we,
    input  logic [CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [CFG_DATA_W-1:0]  i_cfg_data
);

    localparam int JOB_W = $bits(t_job_ctl) + TAPS * SAMPLE_BITS;

    // configuration registers
    logic [LR_W-1:0]                        r_left_taps;
    logic [LR_W-1:0]                        r_right_taps;
    logic [COEF_WORDS-1:0][CFG_DATA_W-1:0]  r_coeff;
    logic [COEF_LANES-1:0][COEF_W-1:0]      coef_lanes;

    // front to job queue
    logic                                   accept;
    logic                                   job_push;
    t_job_ctl                               job_ctl_in;
    logic [TAPS-1:0][SAMPLE_BITS-1:0]       job_win_in;
    logic [JOB_W-1:0]                       jq_din;
    logic                                   jq_full;

    // job queue to back
    logic [JOB_W-1:0]                       jq_dout;
    logic                                   jq_empty;
    logic                                   job_pop;
    t_job_ctl                               job_ctl_out;
    logic [TAPS-1:0][SAMPLE_BITS-1:0]       job_win_out;

    // back to result queue
    logic                                   res_push;
    t_result                                res_in;
    t_result                                res_out;
    logic [OQ_CNT_W-1:0]                    oq_count;
    logic                                   oq_full;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_left_taps  <= '0;
            r_right_taps <= '0;
            r_coeff[0]   <= COEFF_WORD0_RST;
            r_coeff[1]   <= '0;
            r_coeff[2]   <= '0;
            r_coeff[3]   <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_LEFT_TAPS:   r_left_taps  <= i_cfg_data[LR_W-1:0];
                CFG_RIGHT_TAPS:  r_right_taps <= i_cfg_data[LR_W-1:0];
                CFG_COEFF_WORD0: r_coeff[0]   <= i_cfg_data;
                CFG_COEFF_WORD1: r_coeff[1]   <= i_cfg_data;
                CFG_COEFF_WORD2: r_coeff[2]   <= i_cfg_data;
                CFG_COEFF_WORD3: r_coeff[3]   <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // lane 0 of word 0 sits in the low bits, so the words flatten directly
    assign coef_lanes = r_coeff;

    // the front can only move when the job queue has room
    assign full   = jq_full;
    assign accept = push && !jq_full;

    cwsf_front #(
        .TAPS        (TAPS),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_accept     (accept),
        .i_sample     (i_sample),
        .i_frame_end  (i_frame_end),
        .i_left_taps  (r_left_taps),
        .i_right_taps (r_right_taps),
        .o_job_push   (job_push),
        .o_job_ctl    (job_ctl_in),
        .o_job_win    (job_win_in)
    );

    // each job carries a snapshot of the whole sample window
    assign jq_din = {job_ctl_in, job_win_in};

    cwsf_fifo #(
        .WIDTH (JOB_W),
        .DEPTH (JQ_DEPTH)
    ) u_job_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (job_push),
        .i_data  (jq_din),
        .o_full  (jq_full),
        .i_pop   (job_pop),
        .o_empty (jq_empty),
        .o_data  (jq_dout),
        .o_count ()
    );

    assign {job_ctl_out, job_win_out} = jq_dout;

    cwsf_back #(
        .TAPS        (TAPS),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job_valid (!jq_empty),
        .i_job_ctl   (job_ctl_out),
        .i_job_win   (job_win_out),
        .o_job_pop   (job_pop),
        .i_coef      (coef_lanes),
        .i_oq_count  (oq_count),
        .o_res_push  (res_push),
        .o_res       (res_in)
    );

    // result queue; the back never pushes without credit
    cwsf_fifo #(
        .WIDTH ($bits(t_result)),
        .DEPTH (OQ_DEPTH)
    ) u_res_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (res_push),
        .i_data  (res_in),
        .o_full  (oq_full),
        .i_pop   (pop),
        .o_empty (empty),
        .o_data  (res_out),
        .o_count (oq_count)
    );

    assign o_smoothed   = res_out.smoothed;
    assign o_frame_last = res_out.frame_last;

    // full result queue must mean nothing is in the datapath behind it
    a_oq_full_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        oq_full |=> !res_push || $past(pop))
        else $error("result queue overrun");

endmodule
